FILE: rtl/reb_pkg.sv
// Shared types and constants for the rotary encoder button event block.
`timescale 1ns / 1ps

package reb_pkg;

    localparam int OP_W    = 2;
    localparam int EVENT_W = 2;
    localparam int COUNT_W = 32;
    localparam int TICKS_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [OP_W-1:0]           op_t;
    typedef logic [EVENT_W-1:0]        event_t;
    typedef logic signed [COUNT_W-1:0] count_t;
    typedef logic [TICKS_W-1:0]        ticks_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

    // operations
    localparam op_t OP_TICK = 2'd0;
    localparam op_t OP_EDGE = 2'd1;
    localparam op_t OP_TAKE = 2'd2;

    // button events
    localparam event_t EV_NONE  = 2'd0;
    localparam event_t EV_CLICK = 2'd1;
    localparam event_t EV_LONG  = 2'd2;

    // register indexes
    localparam cfg_idx_t REG_LONG_PRESS_TICKS = 3'd0;
    localparam cfg_idx_t REG_RELEASED_STEP    = 3'd1;
    localparam cfg_idx_t REG_RELEASED_MIN     = 3'd2;
    localparam cfg_idx_t REG_RELEASED_MAX     = 3'd3;
    localparam cfg_idx_t REG_PRESSED_STEP     = 3'd4;
    localparam cfg_idx_t REG_PRESSED_MIN      = 3'd5;
    localparam cfg_idx_t REG_PRESSED_MAX      = 3'd6;

    // register reset values
    localparam ticks_t LONG_PRESS_RESET = 16'd800;
    localparam count_t STEP_RESET       = 32'sd1;
    localparam count_t COUNT_MIN        = 32'h8000_0000;
    localparam count_t COUNT_MAX        = 32'h7FFF_FFFF;

endpackage

FILE: rtl/reb_if.sv
// Request and result channel interfaces of the rotary encoder button event block.
`timescale 1ns / 1ps

interface reb_item_if;
    logic          valid;
    logic          ready;
    reb_pkg::op_t  op;
    logic          button_down;
    logic          dir_cw;

    modport source (output valid, output op, output button_down, output dir_cw,
                    input ready);
    modport sink   (input valid, input op, input button_down, input dir_cw,
                    output ready);
endinterface

interface reb_result_if;
    logic             valid;
    logic             ready;
    reb_pkg::event_t  event_res;
    reb_pkg::count_t  released_count;
    reb_pkg::count_t  pressed_count;

    modport source (output valid, output event_res, output released_count,
                    output pressed_count, input ready);
    modport sink   (input valid, input event_res, input released_count,
                    input pressed_count, output ready);
endinterface

FILE: rtl/reb_step_clamp.sv
// Exact counter step followed by clamping to a min/max range.
`timescale 1ns / 1ps

module reb_step_clamp (
    input  reb_pkg::count_t cur,
    input  reb_pkg::count_t step,
    input  logic            cw,
    input  reb_pkg::count_t lo,
    input  reb_pkg::count_t hi,
    output reb_pkg::count_t result
);
    import reb_pkg::*;

    localparam int SUM_W = COUNT_W + 2;

    logic signed [SUM_W-1:0] cur_x;
    logic signed [SUM_W-1:0] step_x;
    logic signed [SUM_W-1:0] lo_x;
    logic signed [SUM_W-1:0] hi_x;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] clamped;

    assign cur_x  = SUM_W'(cur);
    assign step_x = SUM_W'(step);
    assign lo_x   = SUM_W'(lo);
    assign hi_x   = SUM_W'(hi);

    always_comb
    begin
        sum = cw ? (cur_x + step_x) : (cur_x - step_x);
        clamped = sum;
        if (clamped > hi_x)
        begin
            clamped = hi_x;
        end
        // inverted range ends at min
        if (clamped < lo_x)
        begin
            clamped = lo_x;
        end
    end

    assign result = count_t'(clamped[COUNT_W-1:0]);

endmodule

FILE: rtl/rotary_encoder_button_events.sv
// Top level of the rotary encoder button event block.
`timescale 1ns / 1ps

// Takes one request per clock: a 1 ms tick with the button level, a rotation
// edge with button level and direction, or a take-event request. Every request
// gives exactly one result, carrying the taken event (take requests only) and
// both counters after the request. All work is done in the accepting cycle and
// lands in a single result register, so the block sustains one request per
// cycle and the result is registered; a request is taken whenever the result
// register is empty or is being drained in the same cycle. Configuration
// writes through cfg_we/cfg_index/cfg_data are meant for idle periods only.
module rotary_encoder_button_events #(
    parameter int TICK_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  reb_pkg::cfg_idx_t  cfg_index,
    input  reb_pkg::cfg_data_t cfg_data,
    reb_item_if.sink           item,
    reb_result_if.source       result
);
    import reb_pkg::*;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_PRESSING = 2'd1;
    localparam logic [1:0] PH_LONG     = 2'd2;
    localparam logic [1:0] PH_ROTATED  = 2'd3;

    localparam int CMP_W = (TICK_WIDTH > TICKS_W) ? TICK_WIDTH : TICKS_W;
    localparam logic [TICK_WIDTH-1:0] HOLD_MAX = {TICK_WIDTH{1'b1}};

    // configuration
    ticks_t long_press_ticks_reg;
    count_t released_step_reg, released_min_reg, released_max_reg;
    count_t pressed_step_reg, pressed_min_reg, pressed_max_reg;

    // button and counter state
    logic [1:0]            phase_reg, phase_next;
    logic [TICK_WIDTH-1:0] hold_reg, hold_next;
    logic [TICK_WIDTH-1:0] hold_inc;
    logic                  turned_reg, turned_next;
    event_t                pending_reg, pending_next;
    count_t                released_reg, released_next;
    count_t                pressed_reg, pressed_next;
    count_t                released_stepped, pressed_stepped;
    event_t                event_next;

    // result register
    logic   out_valid_reg;
    event_t out_event_reg;
    count_t out_released_reg;
    count_t out_pressed_reg;

    logic accept;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ticks_reg <= LONG_PRESS_RESET;
            released_step_reg    <= STEP_RESET;
            released_min_reg     <= COUNT_MIN;
            released_max_reg     <= COUNT_MAX;
            pressed_step_reg     <= STEP_RESET;
            pressed_min_reg      <= COUNT_MIN;
            pressed_max_reg      <= COUNT_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_data[TICKS_W-1:0];
                REG_RELEASED_STEP:    released_step_reg    <= count_t'(cfg_data);
                REG_RELEASED_MIN:     released_min_reg     <= count_t'(cfg_data);
                REG_RELEASED_MAX:     released_max_reg     <= count_t'(cfg_data);
                REG_PRESSED_STEP:     pressed_step_reg     <= count_t'(cfg_data);
                REG_PRESSED_MIN:      pressed_min_reg      <= count_t'(cfg_data);
                REG_PRESSED_MAX:      pressed_max_reg      <= count_t'(cfg_data);
                default: ;
            endcase
        end
    end

    reb_step_clamp u_released_clamp (
        .cur    (released_reg),
        .step   (released_step_reg),
        .cw     (item.dir_cw),
        .lo     (released_min_reg),
        .hi     (released_max_reg),
        .result (released_stepped)
    );

    reb_step_clamp u_pressed_clamp (
        .cur    (pressed_reg),
        .step   (pressed_step_reg),
        .cw     (item.dir_cw),
        .lo     (pressed_min_reg),
        .hi     (pressed_max_reg),
        .result (pressed_stepped)
    );

    assign hold_inc = (hold_reg != HOLD_MAX) ? (hold_reg + 1'b1) : hold_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        hold_next     = hold_reg;
        turned_next   = turned_reg;
        pending_next  = pending_reg;
        released_next = released_reg;
        pressed_next  = pressed_reg;
        event_next    = EV_NONE;

        unique case (item.op)
            OP_TICK:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (item.button_down)
                        begin
                            phase_next  = PH_PRESSING;
                            hold_next   = '0;
                            turned_next = 1'b0;
                        end
                    end
                    PH_PRESSING:
                    begin
                        if (!item.button_down)
                        begin
                            if (!turned_reg)
                            begin
                                pending_next = EV_CLICK;
                            end
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            hold_next = hold_inc;
                            if (CMP_W'(hold_inc) >= CMP_W'(long_press_ticks_reg))
                            begin
                                phase_next   = PH_LONG;
                                pending_next = EV_LONG;
                            end
                        end
                    end
                    default:
                    begin
                        if (!item.button_down)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                endcase
            end
            OP_EDGE:
            begin
                if (item.button_down)
                begin
                    turned_next  = 1'b1;
                    phase_next   = PH_ROTATED;
                    pressed_next = pressed_stepped;
                end
                else
                begin
                    released_next = released_stepped;
                end
            end
            OP_TAKE:
            begin
                event_next   = pending_reg;
                pending_next = EV_NONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hold_reg      <= '0;
            turned_reg    <= 1'b0;
            pending_reg   <= EV_NONE;
            released_reg  <= '0;
            pressed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                hold_reg      <= hold_next;
                turned_reg    <= turned_next;
                pending_reg   <= pending_next;
                released_reg  <= released_next;
                pressed_reg   <= pressed_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_event_reg    <= event_next;
            out_released_reg <= released_next;
            out_pressed_reg  <= pressed_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.event_res      = out_event_reg;
    assign result.released_count = out_released_reg;
    assign result.pressed_count  = out_pressed_reg;

endmodule
